// ----- rtl/psc_pkg.sv -----
// Package: payload types, register indexes and constants for pressure compensation.
package psc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temperature_decidegrees;
        logic signed [31:0] pressure_pascal;
        logic               status;
    } out_item_t;

    localparam logic [2:0] REG_OFFSET_CAL = 3'd0;
    localparam logic [2:0] REG_SENSE_CAL  = 3'd1;
    localparam logic [2:0] REG_TEMP_CAL   = 3'd2;
    localparam logic [2:0] REG_CURVE_CAL  = 3'd3;
    localparam logic [2:0] REG_TEMP_CURVE = 3'd4;
    localparam logic [2:0] REG_OSS        = 3'd5;

    localparam logic [31:0] B6_BIAS   = 32'd4000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] HALF_WORD = 32'h8000_0000;
    localparam logic [31:0] P_C1      = 32'd3038;
    localparam logic [31:0] P_C2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_C3      = 32'd3791;

    localparam int DIV_STAGES = 32;

    // all values handed down the divider chain alongside the division
    typedef struct packed {
        logic        fault;
        logic [31:0] t;
        logic [31:0] b3;
        logic [31:0] up;
        logic [31:0] b6;
        logic [1:0]  oss;
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] b1;
        logic [15:0] b2;
        logic        late_dbl;
    } side_t;

    // one restoring-division step state
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
    } div_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

endpackage

// ----- rtl/psc_div_cell.sv -----
// One restoring-division cell: one quotient bit per cycle while en is high, payload riding alongside.
module psc_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  psc_pkg::div_t   d_in,
    input  logic [31:0]     aux_in,
    output logic            vld_out,
    output psc_pkg::div_t   d_out,
    output logic [31:0]     aux_out
);
    logic [32:0] trial;
    logic [31:0] shifted;
    psc_pkg::div_t d_next;
    logic vld_reg;
    psc_pkg::div_t d_reg;
    logic [31:0] aux_reg;

    always_comb begin
        shifted = {d_in.rem[30:0], d_in.quo[31]};
        trial   = {d_in.rem[31], shifted} - {1'b0, d_in.den};
        d_next  = d_in;
        if (!trial[32]) begin
            d_next.rem = trial[31:0];
            d_next.quo = {d_in.quo[30:0], 1'b1};
        end else begin
            d_next.rem = shifted;
            d_next.quo = {d_in.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            d_reg   <= d_next;
            aux_reg <= aux_in;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;
    assign aux_out = aux_reg;
endmodule

// ----- rtl/psc_divider.sv -----
// Chain of division cells: unsigned 32/32 quotient.
module psc_divider (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_in,
    input  logic [31:0]   num,
    input  logic [31:0]   den,
    input  logic [31:0]   aux_in,
    output logic          vld_out,
    output logic [31:0]   quo,
    output logic [31:0]   aux_out
);
    logic          v [psc_pkg::DIV_STAGES+1];
    psc_pkg::div_t d [psc_pkg::DIV_STAGES+1];
    logic [31:0]   a [psc_pkg::DIV_STAGES+1];

    assign v[0] = vld_in;
    assign d[0] = '{rem: 32'd0, quo: num, den: den};
    assign a[0] = aux_in;

    for (genvar i = 0; i < psc_pkg::DIV_STAGES; i++) begin : g_cell
        psc_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(v[i]), .d_in(d[i]), .aux_in(a[i]),
            .vld_out(v[i+1]), .d_out(d[i+1]), .aux_out(a[i+1])
        );
    end

    assign vld_out = v[psc_pkg::DIV_STAGES];
    assign quo     = d[psc_pkg::DIV_STAGES].quo;
    assign aux_out = a[psc_pkg::DIV_STAGES];
endmodule

// ----- rtl/pressure_sensor_compensation.sv -----
// Top level: pipelined temperature and pressure compensation.
// Input channel s_valid/s_ready/s_item carries raw temperature and raw pressure;
// result channel m_valid/m_ready/m_item returns temperature in 0.1 degC,
// pressure in Pa and a division-fault status bit. One result per item, in order.
// Configuration: cfg_we, cfg_index, cfg_data; index 0..5 as listed, others ignored.
// Throughput: one item per cycle while the output is not stalled. The pipeline is
// made of two chains of 32 one-bit division cells (temperature X2 and pressure P) plus multiply stages.
// The whole pipeline advances only when the output register is free or taken,
// so s_ready follows m_ready or an empty output stage; a stall freezes every stage
// and holds the result on m_item.
// Reset (aresetn low, synchronous) clears all valid bits and the configuration registers to zero.
// Signed divisions are done on magnitudes with the sign fixed afterwards;
// a zero divisor anywhere forces status 1 with both values zero.
module pressure_sensor_compensation (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psc_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output psc_pkg::out_item_t  m_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    logic [31:0] offset_cal_reg, sense_cal_reg, temp_cal_reg, curve_cal_reg, temp_curve_reg;
    logic [1:0]  oss_reg;
    logic        en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_cal_reg <= '0; sense_cal_reg <= '0; temp_cal_reg <= '0;
            curve_cal_reg <= '0; temp_curve_reg <= '0; oss_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                psc_pkg::REG_OFFSET_CAL: offset_cal_reg <= cfg_data;
                psc_pkg::REG_SENSE_CAL:  sense_cal_reg  <= cfg_data;
                psc_pkg::REG_TEMP_CAL:   temp_cal_reg   <= cfg_data;
                psc_pkg::REG_CURVE_CAL:  curve_cal_reg  <= cfg_data;
                psc_pkg::REG_TEMP_CURVE: temp_curve_reg <= cfg_data;
                psc_pkg::REG_OSS:        oss_reg        <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic m_valid_reg;
    psc_pkg::out_item_t m_item_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage A: X1 product
    logic        a_vld_reg;
    logic [31:0] a_prod_reg;
    logic [15:0] a_md_reg, a_mc_reg;
    psc_pkg::side_t a_side, a_cfg_reg;
    always_comb begin
        a_side     = '0;
        a_side.up  = {8'd0, s_item.raw_pressure} >> (4'd8 - {2'd0, oss_reg});
        a_side.oss = oss_reg;
        a_side.ac1 = offset_cal_reg[31:16];
        a_side.ac2 = offset_cal_reg[15:0];
        a_side.ac3 = sense_cal_reg[31:16];
        a_side.ac4 = sense_cal_reg[15:0];
        a_side.b1  = curve_cal_reg[31:16];
        a_side.b2  = curve_cal_reg[15:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en) a_vld_reg <= s_valid;
        if (en) begin
            a_prod_reg <= psc_pkg::mul32({16'd0, s_item.raw_temperature}
                          - {16'd0, temp_cal_reg[15:0]}, {16'd0, temp_cal_reg[31:16]});
            a_cfg_reg  <= a_side;
            a_md_reg   <= temp_curve_reg[15:0];
            a_mc_reg   <= temp_curve_reg[31:16];
        end
    end

    // stage B: denominator, magnitudes for first division
    logic        b_vld_reg, b_zero_reg, b_neg_reg;
    logic [31:0] b_x1_reg, b_num_reg, b_den_reg;
    psc_pkg::side_t b_cfg_reg;
    logic [31:0] b_x1, b_den, b_num, b_mc;
    always_comb begin
        b_x1  = psc_pkg::asr32(a_prod_reg, 15);
        b_den = b_x1 + psc_pkg::sx16(a_md_reg);
        b_mc  = psc_pkg::sx16(a_mc_reg);
        b_num = {b_mc[20:0], 11'd0};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en) b_vld_reg <= a_vld_reg;
        if (en) begin
            b_x1_reg   <= b_x1;
            b_zero_reg <= (b_den == 32'd0);
            b_neg_reg  <= b_num[31] ^ b_den[31];
            b_num_reg  <= b_num[31] ? -b_num : b_num;
            b_den_reg  <= b_den[31] ? -b_den : b_den;
            b_cfg_reg  <= a_cfg_reg;
        end
    end

    // first divider; side data delayed in a matching shift line
    logic        d1_vld;
    logic [31:0] d1_quo, d1_x1;
    psc_pkg::side_t d1_side [psc_pkg::DIV_STAGES];
    logic        d1_zero [psc_pkg::DIV_STAGES];
    logic        d1_neg  [psc_pkg::DIV_STAGES];
    psc_divider u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(b_vld_reg),
        .num(b_num_reg), .den(b_den_reg), .aux_in(b_x1_reg),
        .vld_out(d1_vld), .quo(d1_quo), .aux_out(d1_x1)
    );
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_side[0] <= b_cfg_reg;
            d1_zero[0] <= b_zero_reg;
            d1_neg[0]  <= b_neg_reg;
            for (int i = 1; i < psc_pkg::DIV_STAGES; i++) begin
                d1_side[i] <= d1_side[i-1];
                d1_zero[i] <= d1_zero[i-1];
                d1_neg[i]  <= d1_neg[i-1];
            end
        end
    end

    // stage C: B5, T, B6
    logic c_vld_reg;
    psc_pkg::side_t c_reg, c_side;
    logic [31:0] c_b5;
    always_comb begin
        c_b5 = d1_x1 + (d1_neg[psc_pkg::DIV_STAGES-1] ? -d1_quo : d1_quo);
        c_side       = d1_side[psc_pkg::DIV_STAGES-1];
        c_side.fault = d1_zero[psc_pkg::DIV_STAGES-1];
        c_side.t     = psc_pkg::asr32(c_b5 + 32'd8, 4);
        c_side.b6    = c_b5 - psc_pkg::B6_BIAS;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) c_vld_reg <= 1'b0;
        else if (en) c_vld_reg <= d1_vld;
        if (en) c_reg <= c_side;
    end

    // stage D: products of B6
    logic d_vld_reg;
    psc_pkg::side_t d_reg;
    logic [31:0] d_sq_reg, d_ac2b6_reg, d_ac3b6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) d_vld_reg <= 1'b0;
        else if (en) d_vld_reg <= c_vld_reg;
        if (en) begin
            d_reg       <= c_reg;
            d_sq_reg    <= psc_pkg::asr32(psc_pkg::mul32(c_reg.b6, c_reg.b6), 12);
            d_ac2b6_reg <= psc_pkg::asr32(psc_pkg::mul32(psc_pkg::sx16(c_reg.ac2), c_reg.b6), 11);
            d_ac3b6_reg <= psc_pkg::asr32(psc_pkg::mul32(psc_pkg::sx16(c_reg.ac3), c_reg.b6), 13);
        end
    end

    // stage E: curvature products, B3, X3
    logic e_vld_reg;
    psc_pkg::side_t e_reg, e_side;
    logic [31:0] e_x3_reg;
    logic [31:0] e_b2sq, e_b1sq, e_x3a, e_ac1;
    always_comb begin
        e_b2sq = psc_pkg::asr32(psc_pkg::mul32(psc_pkg::sx16(d_reg.b2), d_sq_reg), 11);
        e_b1sq = psc_pkg::asr32(psc_pkg::mul32(psc_pkg::sx16(d_reg.b1), d_sq_reg), 16);
        e_x3a  = e_b2sq + d_ac2b6_reg;
        e_ac1  = psc_pkg::sx16(d_reg.ac1);
        e_side    = d_reg;
        e_side.b3 = psc_pkg::asr32((({e_ac1[29:0], 2'b00} + e_x3a) << d_reg.oss) + 32'd2, 2);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) e_vld_reg <= 1'b0;
        else if (en) e_vld_reg <= d_vld_reg;
        if (en) begin
            e_reg    <= e_side;
            e_x3_reg <= psc_pkg::asr32(d_ac3b6_reg + e_b1sq + 32'd2, 2);
        end
    end

    // stage F: B4 and B7 products
    logic f_vld_reg;
    psc_pkg::side_t f_reg, f_side;
    logic [31:0] f_b4_reg, f_b7_reg;
    logic [31:0] f_b4, f_b7;
    always_comb begin
        f_b4 = psc_pkg::mul32({16'd0, e_reg.ac4}, e_x3_reg + psc_pkg::B4_BIAS) >> 15;
        f_b7 = psc_pkg::mul32(e_reg.up - e_reg.b3, psc_pkg::B7_SCALE >> e_reg.oss);
        f_side          = e_reg;
        f_side.fault    = e_reg.fault || (f_b4 == 32'd0);
        f_side.late_dbl = (f_b7 >= psc_pkg::HALF_WORD);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg <= 1'b0;
        else if (en) f_vld_reg <= e_vld_reg;
        if (en) begin
            f_reg    <= f_side;
            f_b4_reg <= f_b4;
            f_b7_reg <= f_b7;
        end
    end

    // second divider
    logic        d2_vld;
    logic [31:0] d2_quo, d2_t;
    psc_pkg::side_t d2_side [psc_pkg::DIV_STAGES];
    psc_divider u_div_p (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(f_vld_reg),
        .num(f_reg.late_dbl ? f_b7_reg : {f_b7_reg[30:0], 1'b0}), .den(f_b4_reg),
        .aux_in(f_reg.t), .vld_out(d2_vld), .quo(d2_quo), .aux_out(d2_t)
    );
    always_ff @(posedge aclk) begin
        if (en) begin
            d2_side[0] <= f_reg;
            for (int i = 1; i < psc_pkg::DIV_STAGES; i++) begin
                d2_side[i] <= d2_side[i-1];
            end
        end
    end

    // stage G: p and its square term
    logic g_vld_reg, g_fault_reg;
    logic [31:0] g_p_reg, g_t_reg, g_sq_reg, g_x2_reg;
    logic [31:0] g_p, g_p8;
    always_comb begin
        g_p  = d2_side[psc_pkg::DIV_STAGES-1].late_dbl ? {d2_quo[30:0], 1'b0} : d2_quo;
        g_p8 = psc_pkg::asr32(g_p, 8);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) g_vld_reg <= 1'b0;
        else if (en) g_vld_reg <= d2_vld;
        if (en) begin
            g_fault_reg <= d2_side[psc_pkg::DIV_STAGES-1].fault;
            g_p_reg     <= g_p;
            g_t_reg     <= d2_t;
            g_sq_reg    <= psc_pkg::mul32(g_p8, g_p8);
            g_x2_reg    <= psc_pkg::asr32(psc_pkg::mul32(psc_pkg::P_C2, g_p), 16);
        end
    end

    // stage H: constant product
    logic h_vld_reg, h_fault_reg;
    logic [31:0] h_p_reg, h_t_reg, h_x1_reg, h_x2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) h_vld_reg <= 1'b0;
        else if (en) h_vld_reg <= g_vld_reg;
        if (en) begin
            h_fault_reg <= g_fault_reg;
            h_p_reg     <= g_p_reg;
            h_t_reg     <= g_t_reg;
            h_x1_reg    <= psc_pkg::asr32(psc_pkg::mul32(g_sq_reg, psc_pkg::P_C1), 16);
            h_x2_reg    <= g_x2_reg;
        end
    end

    // output register
    psc_pkg::out_item_t m_item_next;
    always_comb begin
        m_item_next.status = h_fault_reg;
        m_item_next.temperature_decidegrees = h_fault_reg ? 32'sd0 : $signed(h_t_reg);
        m_item_next.pressure_pascal = h_fault_reg ? 32'sd0 : $signed(h_p_reg
            + psc_pkg::asr32(h_x1_reg + h_x2_reg + psc_pkg::P_C3, 4));
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= h_vld_reg;
        if (en) m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
endmodule

// ----- rtl/psc_checker.sv -----
// Port-level checker for pressure_sensor_compensation, bound to the top level.
module psc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input psc_pkg::out_item_t m_item
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item)) else $error("result dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stalled with empty output");
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status |-> m_item.pressure_pascal == 32'sd0
        && m_item.temperature_decidegrees == 32'sd0) else $error("fault not zeroed");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);

// ----- verif/testbench.sv -----
// Testbench for pressure_sensor_compensation: random and directed raw samples checked by a scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class compensation_board;
        logic [31:0]        regs [6];
        psc_pkg::out_item_t pending [$];
        int                 errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            if (idx <= psc_pkg::REG_OSS)
                regs[idx] = (idx == psc_pkg::REG_OSS) ? (val & 32'd3) : val;
        endfunction

        static function logic [31:0] sra(logic [31:0] x, int n);
            return 32'($signed(x) >>> n);
        endfunction

        static function logic [31:0] times(logic [31:0] a, logic [31:0] b);
            logic [63:0] p;
            p = a * b;
            return p[31:0];
        endfunction

        function psc_pkg::out_item_t compensate(psc_pkg::in_item_t it);
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, t, p, den;
            longint q;
            int oss;
            psc_pkg::out_item_t r;
            ac1 = {{16{regs[0][31]}}, regs[0][31:16]};
            ac2 = {{16{regs[0][15]}}, regs[0][15:0]};
            ac3 = {{16{regs[1][31]}}, regs[1][31:16]};
            ac4 = {16'd0, regs[1][15:0]};
            ac5 = {16'd0, regs[2][31:16]};
            ac6 = {16'd0, regs[2][15:0]};
            b1  = {{16{regs[3][31]}}, regs[3][31:16]};
            b2  = {{16{regs[3][15]}}, regs[3][15:0]};
            mc  = {{16{regs[4][31]}}, regs[4][31:16]};
            md  = {{16{regs[4][15]}}, regs[4][15:0]};
            oss = regs[5][1:0];
            ut = {16'd0, it.raw_temperature};
            up = {8'd0, it.raw_pressure} >> (8 - oss);
            r = '0;
            r.status = 1'b1;
            x1 = sra(times(ut - ac6, ac5), 15);
            den = x1 + md;
            if (den == 0) return r;
            q = longint'($signed(mc << 11)) / longint'($signed(den));
            x2 = q[31:0];
            b5 = x1 + x2;
            t = sra(b5 + 32'd8, 4);
            b6 = b5 - 32'd4000;
            sq = sra(times(b6, b6), 12);
            x1 = sra(times(b2, sq), 11);
            x2 = sra(times(ac2, b6), 11);
            x3 = x1 + x2;
            b3 = sra(((times(ac1, 32'd4) + x3) << oss) + 32'd2, 2);
            x1 = sra(times(ac3, b6), 13);
            x2 = sra(times(b1, sq), 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = times(ac4, x3 + 32'd32768) >> 15;
            if (b4 == 0) return r;
            b7 = times(up - b3, 32'd50000 >> oss);
            if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
            else p = (b7 / b4) << 1;
            x1 = times(sra(p, 8), sra(p, 8));
            x1 = sra(times(x1, 32'd3038), 16);
            x2 = sra(times(32'hFFFF_E343, p), 16);
            p = p + sra(x1 + x2 + 32'd3791, 4);
            r.temperature_decidegrees = t;
            r.pressure_pascal = p;
            r.status = 1'b0;
            return r;
        endfunction

        function void note_sample(psc_pkg::in_item_t it);
            pending.push_back(compensate(it));
        endfunction

        function void check_result(psc_pkg::out_item_t got);
            psc_pkg::out_item_t exp_r;
            if (pending.size() == 0) begin
                $error("result with no sample outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.temperature_decidegrees !== exp_r.temperature_decidegrees) begin
                $error("temperature_decidegrees exp %0d got %0d",
                       exp_r.temperature_decidegrees, got.temperature_decidegrees);
                errors++;
            end
            if (got.pressure_pascal !== exp_r.pressure_pascal) begin
                $error("pressure_pascal exp %0d got %0d",
                       exp_r.pressure_pascal, got.pressure_pascal);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status exp %0b got %0b", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 72;
    localparam longint CYCLE_LIMIT = 400000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    psc_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 0;
    psc_pkg::out_item_t m_item;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    compensation_board board = new();
    longint cycles = 0;
    bit     sink_on = 0;

    pressure_sensor_compensation dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (m_valid && m_ready) board.check_result(m_item);
    end

    // result side stalls
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (!sink_on) begin
                m_ready <= 1'b0;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(logic [15:0] ut, logic [23:0] up, bit no_gap);
        psc_pkg::in_item_t it;
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        it.raw_temperature = ut;
        it.raw_pressure = up;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_sample(it);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        @(negedge aclk);
    endtask

    // realistic calibration set, with every field slightly randomized
    task automatic load_typical();
        write_reg(psc_pkg::REG_OFFSET_CAL, {16'(408 + $urandom_range(0, 400)),
                                            16'(-72 - $urandom_range(0, 100))});
        write_reg(psc_pkg::REG_SENSE_CAL, {16'(-14383 + $urandom_range(0, 800)),
                                           16'(32741 + $urandom_range(0, 800))});
        write_reg(psc_pkg::REG_TEMP_CAL, {16'(32757 - $urandom_range(0, 800)),
                                          16'(23153 + $urandom_range(0, 800))});
        write_reg(psc_pkg::REG_CURVE_CAL, {16'(6190 + $urandom_range(0, 200)),
                                           16'(4 + $urandom_range(0, 20))});
        write_reg(psc_pkg::REG_TEMP_CURVE, {16'(-8711 + $urandom_range(0, 400)),
                                            16'(2868 - $urandom_range(0, 200))});
    endtask

    task automatic random_phase(int n, bit typical_raw);
        logic [15:0] ut;
        logic [23:0] up;
        for (int i = 0; i < n; i++) begin
            if (typical_raw) begin
                ut = 16'($urandom_range(20000, 34000));
                up = 24'($urandom_range(2500000, 6000000));
            end else begin
                ut = 16'($urandom);
                up = 24'($urandom);
            end
            send_sample(ut, up, 0);
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        sink_on = 1;

        // all registers zero: both divisors degenerate, fault path
        send_sample(16'h0000, 24'h000000, 0);
        send_sample(16'hFFFF, 24'hFFFFFF, 0);
        drain();

        load_typical();
        write_reg(psc_pkg::REG_OSS, 32'd0);
        send_sample(16'd27898, 24'd23843 << 8, 1);
        send_sample(16'h0000, 24'h000000, 1);
        send_sample(16'hFFFF, 24'hFFFFFF, 1);
        send_sample(16'h8000, 24'h800000, 0);
        send_sample(16'h7FFF, 24'h7FFFFF, 0);
        drain();

        // temperature divisor zero: ac5 = 0 so x1 = 0, md = 0
        write_reg(psc_pkg::REG_TEMP_CURVE, {16'd100, 16'd0});
        write_reg(psc_pkg::REG_TEMP_CAL, {16'd0, 16'd1000});
        send_sample(16'd1234, 24'd555, 0);
        send_sample(16'hFFFF, 24'hFFFFFF, 0);
        drain();

        // pressure divisor zero: ac4 = 0
        load_typical();
        write_reg(psc_pkg::REG_SENSE_CAL, {16'h8000, 16'd0});
        send_sample(16'd27898, 24'd6000000, 0);
        drain();

        // extreme coefficients to hit wraps and large B7
        write_reg(psc_pkg::REG_OFFSET_CAL, 32'h8000_7FFF);
        write_reg(psc_pkg::REG_SENSE_CAL, 32'h7FFF_FFFF);
        write_reg(psc_pkg::REG_TEMP_CAL, 32'hFFFF_0000);
        write_reg(psc_pkg::REG_CURVE_CAL, 32'h7FFF_8000);
        write_reg(psc_pkg::REG_TEMP_CURVE, 32'h8000_7FFF);
        write_reg(psc_pkg::REG_OSS, 32'd3);
        send_sample(16'h0000, 24'hFFFFFF, 0);
        send_sample(16'hFFFF, 24'h000000, 0);
        send_sample(16'h5555, 24'hAAAAAA, 0);
        send_sample(16'hAAAA, 24'h555555, 0);
        drain();
        write_reg(psc_pkg::REG_OFFSET_CAL, 32'hFFFF_FFFF);
        write_reg(psc_pkg::REG_CURVE_CAL, 32'h8000_7FFF);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_sample(16'h1234, 24'hFFFFFF, 0);
        send_sample(16'hFEDC, 24'h000001, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 4 == 3) begin
                for (int r = 0; r < 5; r++) write_reg(3'(r), $urandom);
            end else begin
                load_typical();
            end
            write_reg(psc_pkg::REG_OSS, 32'(ph % 4));
            random_phase(70, ph % 2 == 0);
            random_phase(40, 0);
            drain();
        end

        if (board.pending.size() == 0 && board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
